### src/pptu_pkg.sv
// Shared constants, types and codes for the pulse period timemark unit.
package pptu_pkg;

    // channel count and widths of the fields
    localparam int CHANNELS   = 4;
    localparam int TM_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_W       = 2;
    localparam int CNT_W      = 32;
    localparam int NAVG_W     = 11;
    localparam int CLK_W      = 32;
    localparam int QUO_W      = 64;
    localparam int TM_W       = 64;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 32;

    // serial multiplier and divider sizing
    localparam int MUL_W      = CLK_W + NAVG_W;
    localparam int MUL_CW     = $clog2(NAVG_W + 1);
    localparam int DVS_W      = 32;
    localparam int DIV_STEPS  = QUO_W;
    localparam int DIV_CW     = $clog2(DIV_STEPS);

    // output mode codes
    localparam logic [MODE_W-1:0] MODE_COUNT    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREQ     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TIMEMARK = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIODS_AVERAGED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ         = 2'd2;

    // register reset values
    localparam logic [MODE_W-1:0] MODE_RESET    = MODE_COUNT;
    localparam logic [NAVG_W-1:0] NAVG_RESET    = 11'd1;
    localparam logic [CLK_W-1:0]  CLK_HZ_RESET  = 32'd125000000;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALIB,
        ST_MUL,
        ST_RD_CH,
        ST_RD_FS,
        ST_DIV,
        ST_FIN
    } pptu_state_t;

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [QUO_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } pptu_div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } pptu_div_rsp_t;

endpackage

### src/pptu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pptu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/pptu_div.sv
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
module pptu_div
    import pptu_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  pptu_div_req_t req,
    output pptu_div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [QUO_W-1:0]  dq_reg;
    logic [DVS_W-1:0]  r_reg;
    logic [DVS_W-1:0]  d_reg;

    logic [DVS_W:0]    shifted;
    logic [DVS_W:0]    diff;
    logic              fits;

    // trial subtract of the divisor from the shifted partial remainder
    assign shifted = {r_reg, dq_reg[QUO_W-1]};
    assign diff    = shifted - {1'b0, d_reg};
    assign fits    = (shifted >= {1'b0, d_reg});

    // control: start, step count, done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CW'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: shift the dividend out and the quotient bits in
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dq_reg <= req.dividend;
            r_reg  <= '0;
            d_reg  <= req.divisor;
        end
        else if (busy_reg)
        begin
            dq_reg <= {dq_reg[QUO_W-2:0], fits};
            r_reg  <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dq_reg;
    assign rsp.remainder = r_reg;

endmodule

### src/pulse_period_timemark_unit_core.sv
// Top level: calibration, mode sequencing, timemark store and result register.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------------------
//  in       | request   | in_valid / in_stall  | channel, raw_capture
//  out      | result    | out_valid / out_stall| channel_out, corrected_count, quotient,
//           |           |                      | remainder, divide_error
//  cfg      | write     | cfg_we               | cfg_index, cfg_wdata
//
// One request is worked on at a time. Count mode loads the result after calibration;
// timemark and frequency modes use the 64-step serial divider unless the divisor is zero,
// and frequency mode first runs the serial clock_hz * N multiplier (11 shift-add steps).
// The next request is taken in the cycle after the result loads, even if it still waits.
// Reset clears the timemark store through per-channel valid bits; no clearing pass.
// A stalled result holds; the sequencer waits at the end until the output register frees.
module pulse_period_timemark_unit_core
    import pptu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CH_W-1:0]      channel,
    input  logic [CNT_W-1:0]     raw_capture,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CH_W-1:0]      channel_out,
    output logic [CNT_W-1:0]     corrected_count,
    output logic [QUO_W-1:0]     quotient,
    output logic [DVS_W-1:0]     remainder,
    output logic                 divide_error,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    // control state
    pptu_state_t          state_reg, state_next;
    logic [MODE_W-1:0]    mode_reg;
    logic [NAVG_W-1:0]    navg_reg;
    logic [CLK_W-1:0]     clk_hz_reg;
    logic                 fs_valid_reg, fs_valid_next;
    logic [CH_W-1:0]      fs_ch_reg, fs_ch_next;
    logic [CHANNELS-1:0]  tm_valid_reg, tm_valid_next;
    logic [MUL_CW-1:0]    mul_cnt_reg, mul_cnt_next;
    logic                 out_valid_reg, out_valid_next;

    // payload
    logic [CH_W-1:0]      ch_reg, ch_next;
    logic [CNT_W-1:0]     raw_reg, raw_next;
    logic [CNT_W-1:0]     cor_reg, cor_next;
    logic [TM_W-1:0]      base_reg, base_next;
    logic                 load_fs_reg, load_fs_next;
    logic [NAVG_W-1:0]    n_sh_reg, n_sh_next;
    logic [MUL_W-1:0]     mul_acc_reg, mul_acc_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic                 err_reg, err_next;
    logic [CH_W-1:0]      out_ch_reg, out_ch_next;
    logic [CNT_W-1:0]     out_cor_reg, out_cor_next;
    logic [QUO_W-1:0]     out_quo_reg, out_quo_next;
    logic [DVS_W-1:0]     out_rem_reg, out_rem_next;
    logic                 out_err_reg, out_err_next;

    // datapath helpers
    logic [CNT_W-1:0]     inv;
    logic [12:0]          avg_term;
    logic [CNT_W-1:0]     cal_count;
    logic [TM_AW-1:0]     ch_addr;
    logic [TM_AW-1:0]     fs_addr;
    logic                 ch_in_range;
    logic                 fs_in_range;
    logic                 ram_we;
    logic [TM_AW-1:0]     ram_raddr;
    logic [TM_W-1:0]      ram_rdata;
    logic [TM_W-1:0]      tm_ch_val;
    logic [TM_W-1:0]      tm_fs_val;
    logic [TM_W-1:0]      tm_sum;
    pptu_div_req_t        div_req;
    pptu_div_rsp_t        div_rsp;

    // timemark store
    pptu_ram #(
        .WIDTH (TM_W),
        .DEPTH (CHANNELS)
    ) u_tm_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ch_addr),
        .wdata (tm_sum),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared serial divider
    pptu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // invert and calibrate: 2x+4 for one period, else 2x+3N+3
    assign inv       = ~raw_reg;
    assign avg_term  = (navg_reg == NAVG_W'(1)) ? 13'd4
                     : 13'(navg_reg) + 13'({navg_reg, 1'b0}) + 13'd3;
    assign cal_count = {inv[CNT_W-2:0], 1'b0} + CNT_W'(avg_term);

    // store addressing and the first-seen channel
    assign ch_addr     = TM_AW'(ch_reg);
    assign fs_addr     = TM_AW'(fs_ch_reg);
    assign ch_in_range = (32'(ch_reg) < CHANNELS);
    assign fs_in_range = (32'(fs_ch_reg) < CHANNELS);
    assign tm_ch_val   = tm_valid_reg[ch_addr] ? ram_rdata : '0;
    assign tm_fs_val   = tm_valid_reg[fs_addr] ? ram_rdata : '0;
    assign tm_sum      = (load_fs_reg ? tm_fs_val : base_reg) + TM_W'(cor_reg);

    // sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        fs_valid_next  = fs_valid_reg;
        fs_ch_next     = fs_ch_reg;
        tm_valid_next  = tm_valid_reg;
        mul_cnt_next   = mul_cnt_reg;
        out_valid_next = out_valid_reg;
        ch_next        = ch_reg;
        raw_next       = raw_reg;
        cor_next       = cor_reg;
        base_next      = base_reg;
        load_fs_next   = load_fs_reg;
        n_sh_next      = n_sh_reg;
        mul_acc_next   = mul_acc_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        err_next       = err_reg;
        out_ch_next    = out_ch_reg;
        out_cor_next   = out_cor_reg;
        out_quo_next   = out_quo_reg;
        out_rem_next   = out_rem_reg;
        out_err_next   = out_err_reg;
        in_stall       = 1'b1;
        ram_we         = 1'b0;
        ram_raddr      = ch_addr;
        div_req        = '0;

        // drop a result once it is taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ch_next    = channel;
                    raw_next   = raw_capture;
                    state_next = ST_CALIB;
                end
            end

            ST_CALIB:
            begin
                cor_next     = cal_count;
                quo_next     = '0;
                rem_next     = '0;
                err_next     = 1'b0;
                n_sh_next    = navg_reg;
                mul_cnt_next = '0;
                mul_acc_next = '0;
                ram_raddr    = ch_addr;
                if (mode_reg == MODE_FREQ)
                begin
                    state_next = ST_MUL;
                end
                else if (mode_reg == MODE_TIMEMARK && ch_in_range)
                begin
                    if (!fs_valid_reg)
                    begin
                        fs_valid_next = 1'b1;
                        fs_ch_next    = ch_reg;
                    end
                    state_next = ST_RD_CH;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end

            ST_MUL:
            begin
                if (mul_cnt_reg == MUL_CW'(NAVG_W))
                begin
                    if (cor_reg == '0)
                    begin
                        quo_next   = '1;
                        err_next   = 1'b1;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = QUO_W'(mul_acc_reg);
                        div_req.divisor  = cor_reg;
                        state_next       = ST_DIV;
                    end
                end
                else
                begin
                    // shift-add one bit of N, most significant first
                    mul_acc_next = {mul_acc_reg[MUL_W-2:0], 1'b0}
                                 + (n_sh_reg[NAVG_W-1] ? MUL_W'(clk_hz_reg) : '0);
                    n_sh_next    = {n_sh_reg[NAVG_W-2:0], 1'b0};
                    mul_cnt_next = mul_cnt_reg + 1'b1;
                end
            end

            ST_RD_CH:
            begin
                // an empty accumulator inherits the first channel's timemark
                base_next    = tm_ch_val;
                load_fs_next = (tm_ch_val == '0) && (fs_ch_reg != ch_reg) && fs_in_range;
                ram_raddr    = fs_addr;
                state_next   = ST_RD_FS;
            end

            ST_RD_FS:
            begin
                ram_we                 = 1'b1;
                tm_valid_next[ch_addr] = 1'b1;
                if (clk_hz_reg == '0)
                begin
                    quo_next   = '1;
                    err_next   = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = tm_sum;
                    div_req.divisor  = clk_hz_reg;
                    state_next       = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    quo_next   = div_rsp.quotient;
                    rem_next   = div_rsp.remainder;
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_ch_next    = ch_reg;
                    out_cor_next   = cor_reg;
                    out_quo_next   = quo_reg;
                    out_rem_next   = rem_reg;
                    out_err_next   = err_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fs_valid_reg  <= 1'b0;
            fs_ch_reg     <= '0;
            tm_valid_reg  <= '0;
            mul_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fs_valid_reg  <= fs_valid_next;
            fs_ch_reg     <= fs_ch_next;
            tm_valid_reg  <= tm_valid_next;
            mul_cnt_reg   <= mul_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RESET;
            navg_reg   <= NAVG_RESET;
            clk_hz_reg <= CLK_HZ_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OUTPUT_MODE:      mode_reg   <= cfg_wdata[MODE_W-1:0];
                REG_PERIODS_AVERAGED: navg_reg   <= cfg_wdata[NAVG_W-1:0];
                REG_CLOCK_HZ:         clk_hz_reg <= cfg_wdata[CLK_W-1:0];
                default:
                begin
                    mode_reg <= mode_reg;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ch_reg      <= ch_next;
        raw_reg     <= raw_next;
        cor_reg     <= cor_next;
        base_reg    <= base_next;
        load_fs_reg <= load_fs_next;
        n_sh_reg    <= n_sh_next;
        mul_acc_reg <= mul_acc_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        err_reg     <= err_next;
        out_ch_reg  <= out_ch_next;
        out_cor_reg <= out_cor_next;
        out_quo_reg <= out_quo_next;
        out_rem_reg <= out_rem_next;
        out_err_reg <= out_err_next;
    end

    assign out_valid       = out_valid_reg;
    assign channel_out     = out_ch_reg;
    assign corrected_count = out_cor_reg;
    assign quotient        = out_quo_reg;
    assign remainder       = out_rem_reg;
    assign divide_error    = out_err_reg;

endmodule
